// File: hdl/flow_keyword_app_classifier_core_assert.svh
// assertion macros for the keyword classifier
`ifndef FLOW_KEYWORD_APP_CLASSIFIER_CORE_ASSERT_SVH
`define FLOW_KEYWORD_APP_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define FKAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// checked during reset too
`define FKAC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: reset assertion failed");
`else
`define FKAC_ASSERT(lbl, prop)
`define FKAC_ASSERT_RST(lbl, prop)
`endif

`endif

// File: hdl/fkac_pkg.sv
// shared types, keyword table and helpers of the keyword classifier
`default_nettype none
package fkac_pkg;

  localparam int KW_COUNT    = 10;
  localparam int KW_MAX_LEN  = 10;
  localparam int WIN_DEPTH   = KW_MAX_LEN - 1;
  localparam int ROM_ENTRIES = 10;
  localparam int ROM_WIDTH   = 10;

  typedef logic [7:0]                  byte_t;
  typedef logic [KW_COUNT-1:0]         kw_vec_t;
  typedef logic [KW_COUNT-1:0][7:0]    exp_row_t;
  typedef logic [3:0]                  app_code_t;
  typedef logic [1:0]                  proto_t;
  typedef logic [15:0]                 port_t;

  localparam proto_t PROTO_WEB     = 2'd0;
  localparam proto_t PROTO_NAME    = 2'd1;
  localparam proto_t PROTO_SSH     = 2'd2;
  localparam proto_t PROTO_UNKNOWN = 2'd3;

  localparam port_t PORT_HTTPS = 16'd443;
  localparam port_t PORT_HTTP  = 16'd80;
  localparam port_t PORT_DNS   = 16'd53;
  localparam port_t PORT_SSH   = 16'd22;

  localparam app_code_t APP_NONE = 4'd0;

  // window cell controls
  typedef struct packed {
    logic shift;
    logic clr;
  } win_ctl_t;

  typedef struct packed {
    proto_t    protocol_class;
    app_code_t app_code;
  } res_t;

  // lower-case keyword text, zero padded
  localparam byte_t ROM_TEXT [ROM_ENTRIES][ROM_WIDTH] = '{
    '{8'h67, 8'h6f, 8'h6f, 8'h67, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h79, 8'h6f, 8'h75, 8'h74, 8'h75, 8'h62, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h61, 8'h63, 8'h65, 8'h62, 8'h6f, 8'h6f, 8'h6b, 8'h00, 8'h00},
    '{8'h69, 8'h6e, 8'h73, 8'h74, 8'h61, 8'h67, 8'h72, 8'h61, 8'h6d, 8'h00},
    '{8'h74, 8'h77, 8'h69, 8'h74, 8'h74, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00},
    '{8'h67, 8'h69, 8'h74, 8'h68, 8'h75, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h6c, 8'h6f, 8'h75, 8'h64, 8'h66, 8'h6c, 8'h61, 8'h72, 8'h65},
    '{8'h61, 8'h6d, 8'h61, 8'h7a, 8'h6f, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6e, 8'h65, 8'h74, 8'h66, 8'h6c, 8'h69, 8'h78, 8'h00, 8'h00, 8'h00},
    '{8'h64, 8'h69, 8'h73, 8'h63, 8'h6f, 8'h72, 8'h64, 8'h00, 8'h00, 8'h00}
  };

  localparam int ROM_LEN [ROM_ENTRIES] = '{6, 7, 8, 9, 7, 6, 10, 6, 7, 7};

  function automatic int kw_len(input int idx);
    int len;
    len = 0;
    if (idx >= 0 && idx < ROM_ENTRIES) begin
      len = ROM_LEN[idx];
    end
    return len;
  endfunction

  // keyword is in the table and fits the window
  function automatic logic kw_ok(input int idx);
    int len;
    len = kw_len(idx);
    return (idx < KW_COUNT) && (len > 0) && (len <= KW_MAX_LEN) && (len <= ROM_WIDTH);
  endfunction

  function automatic byte_t kw_char(input int idx, input int pos);
    byte_t c;
    c = 8'h00;
    if (idx >= 0 && idx < ROM_ENTRIES && pos >= 0 && pos < ROM_WIDTH) begin
      c = ROM_TEXT[idx][pos];
    end
    return c;
  endfunction

  // window cell slot holds the byte k = slot + 1 places back
  function automatic logic kw_care(input int idx, input int slot);
    return kw_ok(idx) && (slot + 1 < kw_len(idx));
  endfunction

  function automatic byte_t kw_slot_char(input int idx, input int slot);
    return kw_char(idx, kw_len(idx) - 2 - slot);
  endfunction

  function automatic byte_t fold_case(input byte_t b);
    byte_t r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/fkac_win_cell.sv
// one window cell: holds a folded byte, hands it on, compares it per keyword
`default_nettype none
module fkac_win_cell import fkac_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire win_ctl_t ctl,
  input  wire byte_t    din,
  input  wire exp_row_t exp_byte,
  input  wire kw_vec_t  care,
  output byte_t         dout,
  output kw_vec_t       hit
);

  byte_t byte_r;
  byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clr) begin
      byte_nxt = 8'h00;
    end else if (ctl.shift) begin
      byte_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < KW_COUNT; i++) begin
      hit[i] = !care[i] || (byte_r == exp_byte[i]);
    end
  end

  assign dout = byte_r;

endmodule
`default_nettype wire

// File: hdl/fkac_out_buf.sv
// two-entry result buffer between the matcher and the output port
`default_nettype none
module fkac_out_buf import fkac_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_res,
  input  wire logic pop,
  output logic      full,
  output logic      valid,
  output res_t      head
);

  res_t       ent_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_pop;

  assign do_pop = pop && (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_res;
    end
  end

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: hdl/flow_keyword_app_classifier_core.sv
// top level of the keyword application classifier
`default_nettype none
`include "flow_keyword_app_classifier_core_assert.svh"
// Takes a domain name one byte per word and reports, on the word with tlast,
// the lowest-numbered table keyword found anywhere in the name (letters A-Z
// compared without regard to case) and a protocol class: web if any byte was
// present, else from the ports sampled on that word. While in_tready is high a
// word is taken every cycle: the current byte and a chain of window cells are
// compared against all keywords at once, so the rate is one word per clock,
// and the result is written into a two-entry result buffer on its final word,
// which lets input run on while a result waits; in_tready drops only when both
// entries are held. After each final word the window and the found flags start from clear.
module flow_keyword_app_classifier_core import fkac_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] domain_byte, [23:8] source_port, [39:24] dest_port
  input  wire logic [39:0] in_tdata,
  // end_of_domain
  input  wire logic        in_tlast,
  // [0] byte_present
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] app_code, [5:4] protocol_class, [7:6] zero
  output logic [7:0]       out_tdata
);

  logic     in_fire;
  logic     present;
  byte_t    cur;
  port_t    sport;
  port_t    dport;
  win_ctl_t win_ctl;

  byte_t    chain    [WIN_DEPTH+1];
  kw_vec_t  cell_hit [WIN_DEPTH];
  exp_row_t cell_exp [WIN_DEPTH];
  kw_vec_t  cell_care[WIN_DEPTH];

  kw_vec_t  hit_vec;
  kw_vec_t  seen_upd;
  kw_vec_t  seen_r;
  kw_vec_t  seen_nxt;
  logic     any_r;
  logic     any_nxt;
  logic     any_upd;
  res_t     res;
  res_t     head;
  logic     buf_full;

  assign in_fire = in_tvalid && in_tready;
  assign present = in_tuser[0];
  assign cur     = fold_case(in_tdata[7:0]);
  assign sport   = in_tdata[23:8];
  assign dport   = in_tdata[39:24];

  assign win_ctl.shift = in_fire && present;
  assign win_ctl.clr   = in_fire && in_tlast;

  assign chain[0] = cur;

  for (genvar gk = 0; gk < WIN_DEPTH; gk++) begin : g_cell
    for (genvar gi = 0; gi < KW_COUNT; gi++) begin : g_kw
      assign cell_exp[gk][gi]  = kw_slot_char(gi, gk);
      assign cell_care[gk][gi] = kw_care(gi, gk);
    end

    fkac_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (win_ctl),
      .din      (chain[gk]),
      .exp_byte (cell_exp[gk]),
      .care     (cell_care[gk]),
      .dout     (chain[gk+1]),
      .hit      (cell_hit[gk])
    );
  end

  // a keyword ends at the current byte when its last char and every cell agree
  always_comb begin
    for (int i = 0; i < KW_COUNT; i++) begin
      hit_vec[i] = kw_ok(i) && (cur == kw_char(i, kw_len(i) - 1));
      for (int k = 0; k < WIN_DEPTH; k++) begin
        hit_vec[i] = hit_vec[i] && cell_hit[k][i];
      end
    end
  end

  assign seen_upd = present ? (seen_r | hit_vec) : seen_r;
  assign any_upd  = any_r || present;

  always_comb begin
    seen_nxt = seen_r;
    any_nxt  = any_r;
    if (in_fire) begin
      if (in_tlast) begin
        seen_nxt = '0;
        any_nxt  = 1'b0;
      end else begin
        seen_nxt = seen_upd;
        any_nxt  = any_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      any_r  <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      any_r  <= any_nxt;
    end
  end

  // lowest set flag wins
  always_comb begin
    res.app_code = APP_NONE;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (seen_upd[i]) begin
        res.app_code = app_code_t'(i + 1);
      end
    end
    if (dport == PORT_HTTPS || dport == PORT_HTTP || any_upd) begin
      res.protocol_class = PROTO_WEB;
    end else if (dport == PORT_DNS || sport == PORT_DNS) begin
      res.protocol_class = PROTO_NAME;
    end else if (dport == PORT_SSH || sport == PORT_SSH) begin
      res.protocol_class = PROTO_SSH;
    end else begin
      res.protocol_class = PROTO_UNKNOWN;
    end
  end

  fkac_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire && in_tlast),
    .push_res (res),
    .pop      (out_tready),
    .full     (buf_full),
    .valid    (out_tvalid),
    .head     (head)
  );

  assign in_tready = !buf_full;
  assign out_tdata = {2'b00, head.protocol_class, head.app_code};

  `FKAC_ASSERT(a_last_gives_result, in_fire && in_tlast |=> out_tvalid)
  `FKAC_ASSERT(a_last_clears_state, in_fire && in_tlast |=> (seen_r == '0) && !any_r)
  `FKAC_ASSERT(a_no_spurious_result, !out_tvalid && !(in_fire && in_tlast) |=> !out_tvalid)
  `FKAC_ASSERT_RST(a_reset_empties_buf, !rst_n |=> !out_tvalid)

endmodule
`default_nettype wire
